### design/rrw_pkg.sv
// Package: constants, types and result kinds for the reorder receive window.
package rrw_pkg;
   localparam int WindowDefault = 32;
   localparam int SegmentBytesDefault = 1024;
   localparam int SpanCap = 32;
   localparam logic [30:0] InitialSequenceReset = 31'd67;
   localparam logic [5:0] WindowSlotsReset = 6'd32;

   typedef enum logic [1:0] {
      KIND_DELIVER = 2'd0,
      KIND_ACK     = 2'd1,
      KIND_FINISH  = 2'd2
   } kind_type;

   typedef enum logic {
      CSR_INITIAL_SEQUENCE = 1'b0,
      CSR_WINDOW_SLOTS     = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [30:0] seq;
      logic [10:0] len;
      logic        fin;
      logic [15:0] tag;
   } segment_type;

   typedef struct packed {
      segment_type seg;
      logic        stale;
   } front_type;
endpackage

### design/reorder_receive_window.sv
// Top level: reorder receive window with cumulative acknowledgement.
// A stale non-final segment gets an ack; a stored segment gets its in-order deliveries, each
// through the slot read and wait states, then a closing ack or finish, which comes alone
// when nothing is delivered; output stalls hold results back.
// One segment at a time: the next beat is taken only after the last result leaves or it is dropped.
// Synchronous reset clears control state; slot contents are not cleared.
module reorder_receive_window
   import rrw_pkg::*;
#(
   parameter int WINDOW = WindowDefault,
   parameter int SEGMENT_BYTES = SegmentBytesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [30:0] req_segment_seq,
   input  logic [10:0] req_segment_len,
   input  logic        req_is_final,
   input  logic [15:0] req_buffer_tag,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [30:0] rsp_out_seq,
   output logic [10:0] rsp_out_len,
   output logic [15:0] rsp_out_tag,
   output logic [30:0] rsp_ack_value,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [30:0] csr_data
);
   logic        q_valid, q_pop, back_idle;
   front_type   q_data;
   logic [30:0] expected_seq;

   rrw_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_segment_seq, .req_segment_len,
      .req_is_final, .req_buffer_tag, .expected_seq, .back_idle,
      .q_valid, .q_data, .q_pop
   );

   rrw_back #(.WINDOW(WINDOW), .SEGMENT_BYTES(SEGMENT_BYTES)) u_back (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_data,
      .q_valid, .q_data, .q_pop, .expected_seq, .back_idle,
      .rsp_valid, .rsp_stall, .rsp_kind, .rsp_out_seq, .rsp_out_len,
      .rsp_out_tag, .rsp_ack_value, .rsp_last
   );
endmodule

### design/rrw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rrw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

### design/rrw_front.sv
// Front: takes request beats, flags stale sequences, feeds a two-entry queue.
module rrw_front
   import rrw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [30:0] req_segment_seq,
   input  logic [10:0] req_segment_len,
   input  logic        req_is_final,
   input  logic [15:0] req_buffer_tag,
   input  logic [30:0] expected_seq,
   input  logic        back_idle,
   output logic        q_valid,
   output front_type   q_data,
   input  logic        q_pop
);
   front_type   ent_ff [2];
   front_type   ent_in;
   logic        rd_ff, wr_ff;
   logic [1:0]  cnt_ff;
   logic        push;

   // one segment in flight: expected sequence is settled only when back side is idle
   assign req_stall = (cnt_ff != 2'd0) || !back_idle;
   assign push = req_valid && !req_stall;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_data = ent_ff[rd_ff];

   always_comb begin
      ent_in.seg.seq = req_segment_seq;
      ent_in.seg.len = req_segment_len;
      ent_in.seg.fin = req_is_final;
      ent_in.seg.tag = req_buffer_tag;
      ent_in.stale = req_segment_seq < expected_seq;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ff] <= ent_in;
      end
      if (reset) begin
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (q_pop) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, q_pop};
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("pop of empty queue");
   assert property (@(posedge clock) disable iff (reset) push |=> q_valid)
      else $error("accepted beat not queued");
endmodule

### design/rrw_back.sv
// Back: window placement, slot ring, in-order delivery walk and result register.
module rrw_back
   import rrw_pkg::*;
#(
   parameter int WINDOW = WindowDefault,
   parameter int SEGMENT_BYTES = SegmentBytesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [30:0] csr_data,
   input  logic        q_valid,
   input  front_type   q_data,
   output logic        q_pop,
   output logic [30:0] expected_seq,
   output logic        back_idle,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [30:0] rsp_out_seq,
   output logic [10:0] rsp_out_len,
   output logic [15:0] rsp_out_tag,
   output logic [30:0] rsp_ack_value,
   output logic        rsp_last
);
   localparam int AW = $clog2(WINDOW);
   localparam int OW = $clog2(WINDOW + 2);
   localparam int SH = $clog2(SEGMENT_BYTES);
   localparam bit POW2 = (1 << SH) == SEGMENT_BYTES;
   localparam int EffCap = (WINDOW < SpanCap) ? WINDOW : SpanCap;
   localparam int DW = 31 + 11 + 16;

   typedef enum logic [2:0] {
      S_IDLE, S_CALC, S_PLACE, S_READ, S_WAIT, S_EMIT
   } state_type;

   state_type    state_ff;
   logic [30:0]  exp_ff;
   logic [5:0]   win_ff;
   logic         fin_seen_ff, finished_ff;
   logic [AW-1:0] head_ff;
   logic [OW-1:0] high_ff;
   logic [WINDOW-1:0] filled_ff;
   segment_type  seg_ff;
   logic         stale_ff;
   logic [30:0]  diff_ff;
   logic [30:0]  quo_ff;
   logic         out_valid_ff;
   logic [1:0]   kind_ff;
   logic [30:0]  oseq_ff, oack_ff;
   logic [10:0]  olen_ff;
   logic [15:0]  otag_ff;
   logic         olast_ff;

   logic [DW-1:0] rd_data;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [6:0]    effw;
   logic [31:0]   offset;
   logic [AW:0]   pos_sum;
   logic          out_free;
   logic [5:0]    quo_small;
   logic          emit;
   logic          out_valid_in;

   always_comb begin
      effw = (win_ff == 6'd0 || 32'(win_ff) > WINDOW) ? 7'(WINDOW) : {1'b0, win_ff};
      if (32'(effw) > EffCap) effw = 7'(EffCap);
   end

   // slot distance by compare against constant multiples, saturating at SpanCap
   always_comb begin
      quo_small = 6'd0;
      for (int k = 1; k <= SpanCap; k++) begin
         if ({1'b0, diff_ff} >= 32'(k * SEGMENT_BYTES)) quo_small = 6'(k);
      end
   end

   assign offset = stale_ff ? 32'd1 : {1'b0, quo_ff} + 32'd1;
   assign pos_sum = {1'b0, head_ff} + (AW + 1)'(offset - 32'd1);
   assign wr_addr = (32'(pos_sum) >= WINDOW) ? AW'(32'(pos_sum) - WINDOW) : AW'(pos_sum);
   assign wr_en = (state_ff == S_PLACE) && (offset <= 32'(effw));
   assign out_free = !out_valid_ff || !rsp_stall;
   assign emit = out_free && ((state_ff == S_EMIT) ||
                 (state_ff == S_WAIT && high_ff != '0 && filled_ff[head_ff]));
   assign out_valid_in = emit || (out_valid_ff && rsp_stall);

   rrw_ram #(.WIDTH(DW), .DEPTH(1 << AW)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data({seg_ff.seq, seg_ff.len, seg_ff.tag}),
      .rd_addr(head_ff),
      .rd_data(rd_data)
   );

   assign q_pop = (state_ff == S_IDLE) && q_valid;
   assign expected_seq = exp_ff;
   assign back_idle = (state_ff == S_IDLE) && !out_valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_kind = kind_ff;
   assign rsp_out_seq = oseq_ff;
   assign rsp_out_len = olen_ff;
   assign rsp_out_tag = otag_ff;
   assign rsp_ack_value = oack_ff;
   assign rsp_last = olast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         exp_ff <= InitialSequenceReset;
         win_ff <= WindowSlotsReset;
         fin_seen_ff <= 1'b0;
         finished_ff <= 1'b0;
         head_ff <= '0;
         high_ff <= '0;
         filled_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (csr_valid) begin
            if (csr_index == CSR_INITIAL_SEQUENCE) begin
               exp_ff <= csr_data;
            end else begin
               win_ff <= csr_data[5:0];
            end
         end
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  seg_ff <= q_data.seg;
                  stale_ff <= q_data.stale;
                  diff_ff <= q_data.seg.seq - exp_ff;
                  quo_ff <= '0;
                  if (finished_ff) state_ff <= S_IDLE;
                  else if (q_data.stale && !q_data.seg.fin) begin
                     state_ff <= S_EMIT;
                  end else state_ff <= S_CALC;
               end
            end
            S_CALC: begin
               quo_ff <= POW2 ? (diff_ff >> SH) : {25'd0, quo_small};
               state_ff <= S_PLACE;
            end
            S_PLACE: begin
               if (!wr_en) begin
                  state_ff <= S_IDLE;
               end else begin
                  if (seg_ff.fin) fin_seen_ff <= 1'b1;
                  filled_ff[wr_addr] <= 1'b1;
                  if (offset > 32'(high_ff)) high_ff <= OW'(offset);
                  state_ff <= S_READ;
               end
            end
            S_READ: state_ff <= S_WAIT;
            S_WAIT: begin
               if (out_free) begin
                  if (high_ff != '0 && filled_ff[head_ff]) begin
                     kind_ff <= KIND_DELIVER;
                     {oseq_ff, olen_ff, otag_ff} <= rd_data;
                     oack_ff <= '0;
                     olast_ff <= 1'b0;
                     exp_ff <= rd_data[DW-1 -: 31] + 31'(rd_data[26:16]);
                     filled_ff[head_ff] <= 1'b0;
                     head_ff <= AW'(32'(head_ff) + 1 == WINDOW ? 0 : 32'(head_ff) + 1);
                     high_ff <= high_ff - OW'(1);
                     state_ff <= S_READ;
                  end else state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  oseq_ff <= '0;
                  olen_ff <= '0;
                  otag_ff <= '0;
                  olast_ff <= 1'b1;
                  if (!(stale_ff && !seg_ff.fin) && fin_seen_ff && high_ff == '0) begin
                     finished_ff <= 1'b1;
                     kind_ff <= KIND_FINISH;
                     oack_ff <= '0;
                  end else begin
                     kind_ff <= KIND_ACK;
                     oack_ff <= exp_ff;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |=> out_valid_ff && $stable(kind_ff))
      else $error("result changed under stall");
   assert property (@(posedge clock) disable iff (reset)
      finished_ff |=> finished_ff)
      else $error("finished dropped");
   assert property (@(posedge clock) disable iff (reset)
      32'(high_ff) <= EffCap)
      else $error("highest offset beyond window");
endmodule
